@@ rtl/core/ehyp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehyp_pkg
// Shared widths, depths and types of the elementwise hypotenuse unit.
// ----------------------------------------------------------------------------
package ehyp_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int SUM_WIDTH   = 2 * DATA_WIDTH;
    // The remainder of the root never exceeds twice the partial root.
    localparam int REM_WIDTH   = DATA_WIDTH + 1;
    localparam int PART_WIDTH  = DATA_WIDTH + 3;
    // One root bit is resolved in each stage.
    localparam int ROOT_STEPS  = DATA_WIDTH;
    // Magnitude stage, square stage, sum stage and the root stages.
    localparam int NUM_STAGES  = 2 + 1 + ROOT_STEPS;
    localparam int LAST_STAGE  = NUM_STAGES - 1;
    // Words held inside: the pipeline plus the output skid word.
    localparam int MAX_HELD    = NUM_STAGES + 1;
    localparam int COUNT_WIDTH = $clog2(MAX_HELD + 1);

    typedef logic signed [DATA_WIDTH-1:0] sdata_t;
    typedef logic        [DATA_WIDTH-1:0] udata_t;
    typedef logic        [SUM_WIDTH-1:0]  sum_t;
    typedef logic        [REM_WIDTH-1:0]  rem_t;
    typedef logic        [PART_WIDTH-1:0] part_t;
    typedef logic        [COUNT_WIDTH-1:0] count_t;

endpackage

@@ rtl/core/elementwise_hypotenuse_unit.sv @@
// ----------------------------------------------------------------------------
// elementwise_hypotenuse_unit
// Streams pairs of signed Q16.16 elements and returns the floor of
// sqrt(a*a + b*b) as unsigned Q16.16.
//
//   channel   direction  handshake                   payload
//   pair      in         pair_valid / pair_stall     first_value, second_value
//   result    out        result_valid / result_stall magnitude
//
// One word enters per cycle while the skid register is empty; a word passes
// 35 register stages before it shows on the result port. The stages are
// the magnitude and square stages, the sum stage and one stage per root bit.
// Reset clears only the valid bits and the skid flag; data registers hold.
// A stall on the result side parks the last word in a one-word skid
// register and freezes the pipeline until that word is taken.
// ----------------------------------------------------------------------------
module elementwise_hypotenuse_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  ehyp_pkg::sdata_t first_value,
    input  ehyp_pkg::sdata_t second_value,
    output logic             result_valid,
    input  logic             result_stall,
    output ehyp_pkg::udata_t magnitude
);
    import ehyp_pkg::*;

    logic   pipe_en;
    logic   vld_reg   [NUM_STAGES];

    udata_t mag_a_reg;
    udata_t mag_b_reg;
    udata_t mag_a_next;
    udata_t mag_b_next;
    sum_t   sq_a_reg;
    sum_t   sq_b_reg;

    // Root stage j holds the radicand bits still to be consumed, the
    // remainder and the partial root after j steps.
    sum_t   rad_reg   [ROOT_STEPS];
    rem_t   rem_reg   [ROOT_STEPS+1];
    udata_t root_reg  [ROOT_STEPS+1];
    rem_t   rem_next  [ROOT_STEPS+1];
    udata_t root_next [ROOT_STEPS+1];

    logic   skid_full_reg;
    logic   skid_full_next;
    udata_t skid_data_reg;

    assign pipe_en    = !skid_full_reg;
    assign pair_stall = skid_full_reg;

    assign mag_a_next = first_value[DATA_WIDTH-1]  ? udata_t'(-first_value)
                                                   : udata_t'(first_value);
    assign mag_b_next = second_value[DATA_WIDTH-1] ? udata_t'(-second_value)
                                                   : udata_t'(second_value);

    assign rem_next[0]  = '0;
    assign root_next[0] = '0;

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        part_t part;
        part_t trial;
        part_t diff;
        logic  take;

        assign part  = {rem_reg[j], rad_reg[j][SUM_WIDTH-1 -: 2]};
        assign trial = {1'b0, root_reg[j], 2'b01};
        assign diff  = part - trial;
        assign take  = (part >= trial);

        assign rem_next[j+1]  = take ? diff[REM_WIDTH-1:0] : part[REM_WIDTH-1:0];
        assign root_next[j+1] = {root_reg[j][DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= pair_valid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            sq_a_reg    <= SUM_WIDTH'(mag_a_reg) * SUM_WIDTH'(mag_a_reg);
            sq_b_reg    <= SUM_WIDTH'(mag_b_reg) * SUM_WIDTH'(mag_b_reg);
            rad_reg[0]  <= sq_a_reg + sq_b_reg;
            rem_reg[0]  <= rem_next[0];
            root_reg[0] <= root_next[0];
            for (int j = 1; j < ROOT_STEPS; j++)
            begin
                rad_reg[j] <= rad_reg[j-1] << 2;
            end
            for (int j = 1; j <= ROOT_STEPS; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    // The skid word fills when the last stage moves on while the result
    // side is stalled, and empties once it is taken.
    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (!result_stall)
            begin
                skid_full_next = 1'b0;
            end
        end
        else if (vld_reg[LAST_STAGE] && result_stall)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_data_reg <= root_reg[ROOT_STEPS];
        end
    end

    assign result_valid = skid_full_reg || vld_reg[LAST_STAGE];
    assign magnitude    = skid_full_reg ? skid_data_reg : root_reg[ROOT_STEPS];

endmodule

@@ rtl/core/ehyp_checker.sv @@
// ----------------------------------------------------------------------------
// ehyp_checker
// Port-level checks of the elementwise hypotenuse unit, bound to the top.
// ----------------------------------------------------------------------------
module ehyp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pair_valid,
    input logic             pair_stall,
    input ehyp_pkg::sdata_t first_value,
    input ehyp_pkg::sdata_t second_value,
    input logic             result_valid,
    input logic             result_stall,
    input ehyp_pkg::udata_t magnitude
);
    import ehyp_pkg::*;

    logic   in_take;
    logic   out_take;
    count_t held_reg;
    count_t held_next;

    assign in_take  = pair_valid && !pair_stall;
    assign out_take = result_valid && !result_stall;

    // Words accepted and not yet delivered.
    always_comb
    begin
        held_next = held_reg;
        if (in_take && !out_take)
        begin
            held_next = held_reg + count_t'(1);
        end
        else if (out_take && !in_take)
        begin
            held_next = held_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (held_reg != '0))
        else $error("result word shown with no word outstanding");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= count_t'(MAX_HELD))
        else $error("more words outstanding than the unit can hold");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> result_valid)
        else $error("input stalled while no result word is waiting");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(magnitude))
        else $error("stalled result word dropped or changed");

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_stall |=>
            pair_valid && $stable(first_value) && $stable(second_value))
        else $error("stalled pair word dropped or changed");

endmodule

bind elementwise_hypotenuse_unit ehyp_checker u_ehyp_checker (.*);
